// File: design/bcss_pkg.sv
// Shared types, constants and the digit-to-segment map of the button counter
// with seven-segment display. No dependencies; every design file imports it.
package bcss_pkg;

	typedef logic signed [7:0] count_t;
	typedef logic [2:0] levels_t;
	typedef logic [6:0] seg_t;

	// Bit positions inside a button level vector
	localparam int BTN_UP    = 0;
	localparam int BTN_DOWN  = 1;
	localparam int BTN_FORCE = 2;

	localparam count_t COUNT_MAX      = 8'sd99;
	localparam count_t COUNT_EVEN_MAX = 8'sd98;
	localparam count_t COUNT_ZERO     = 8'sd0;
	localparam count_t COUNT_ONE      = 8'sd1;
	localparam count_t COUNT_TWO      = 8'sd2;
	localparam count_t COUNT_FORCE    = -8'sd1;

	localparam logic [3:0] THRESH_RESET = 4'd7;

	// Light scaling: (light - 6) * 10 / 673
	localparam logic [9:0]  LIGHT_OFFSET = 10'd6;
	localparam logic [13:0] LIGHT_DIV    = 14'd673;

	// Force scaling: force * 10 / 827 as force * 12680 >> 20
	localparam logic [23:0] FORCE_RECIP = 24'd12680;
	localparam int          FORCE_SHIFT = 20;

	// Split 0..99 into tens: n * 205 >> 11
	localparam logic [14:0] DIV10_RECIP = 15'd205;
	localparam int          DIV10_SHIFT = 11;

	typedef struct packed {
		logic    active;
		count_t  count_next;
		levels_t prev_next;
		count_t  shown;
	} step_t;

	function automatic seg_t seg_pattern(input logic [3:0] d);
		seg_t p;
		case (d)
			4'd0: p = 7'h3F;
			4'd1: p = 7'h06;
			4'd2: p = 7'h5B;
			4'd3: p = 7'h4F;
			4'd4: p = 7'h66;
			4'd5: p = 7'h6D;
			4'd6: p = 7'h7D;
			4'd7: p = 7'h07;
			4'd8: p = 7'h7F;
			4'd9: p = 7'h67;
			default: p = 7'h00;
		endcase
		return p;
	endfunction

endpackage

// File: design/button_counter_seven_segment_core.sv
// Button counter with two-digit seven-segment output, gated by a light level.
// Uses bcss_pkg, bcss_step and bcss_digits.
//
// One sample beat in, one result beat out. A beat is held in an input register,
// the count update and digit decode run as combinational logic after it, and the
// result sits in an output register; a new sample is taken every cycle while
// the output side keeps up, so throughput is one beat per clock; out_valid rises
// once the beat has moved into the output register. The count and previous button
// levels update as the beat moves into the output register. light_threshold (reset 7)
// is written through cfg_wr_en/cfg_wr_data and must only change while idle.
module button_counter_seven_segment_core import bcss_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [3:0]        cfg_wr_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [9:0]        light_sample,
	input  logic [9:0]        force_sample,
	input  logic              up_button,
	input  logic              down_button,
	input  logic              show_force_button,
	input  logic              even_mode,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [6:0]        tens_segments,
	output logic [6:0]        units_segments,
	output logic              display_active,
	output logic signed [7:0] count_value
);

	logic [3:0] thresh_q;
	count_t     count_q;
	levels_t    prev_q;

	logic       valid_s1;
	logic [9:0] light_s1;
	logic [9:0] force_s1;
	levels_t    levels_s1;
	logic       even_s1;

	logic       valid_s2;
	seg_t       tens_s2;
	seg_t       units_s2;
	logic       active_s2;
	count_t     count_s2;

	logic       adv_s2;
	logic       in_take;
	step_t      step;
	seg_t       tens_d;
	seg_t       units_d;

	assign adv_s2   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv_s2;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RESET;
		end else if (cfg_wr_en) begin
			thresh_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (adv_s2) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			light_s1  <= light_sample;
			force_s1  <= force_sample;
			levels_s1 <= {show_force_button, down_button, up_button};
			even_s1   <= even_mode;
		end
	end

	bcss_step u_step (
		.light_sample    (light_s1),
		.force_sample    (force_s1),
		.levels          (levels_s1),
		.even_mode       (even_s1),
		.count           (count_q),
		.prev_levels     (prev_q),
		.light_threshold (thresh_q),
		.step            (step)
	);

	bcss_digits u_digits (
		.shown          (step.shown),
		.active         (step.active),
		.tens_segments  (tens_d),
		.units_segments (units_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= COUNT_ZERO;
			prev_q   <= '0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= adv_s2 || (valid_s2 && out_stall);
			if (adv_s2) begin
				count_q <= step.count_next;
				prev_q  <= step.prev_next;
			end
		end
	end

	// hold the result until it is taken
	always_ff @(posedge clk) begin
		if (adv_s2) begin
			tens_s2   <= tens_d;
			units_s2  <= units_d;
			active_s2 <= step.active;
			count_s2  <= step.count_next;
		end
	end

	assign out_valid      = valid_s2;
	assign tens_segments  = tens_s2;
	assign units_segments = units_s2;
	assign display_active = active_s2;
	assign count_value    = count_s2;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> ((count_s2 >= COUNT_FORCE) && (count_s2 <= COUNT_MAX)))
		else $error("count out of range");

	a_dark_blank: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !active_s2) |->
		((tens_s2 == 7'h00) && (units_s2 == 7'h00) && (count_s2 == COUNT_ZERO)))
		else $error("dark result not blanked");

	a_state_tracks_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s2 |=> (count_q == count_s2))
		else $error("count state differs from delivered count");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("input stalled without a full pipeline");

endmodule

// File: design/bcss_step.sv
// Count update for one sample: light gating, button edges, mode stepping and
// the value to display. Uses bcss_pkg.
module bcss_step import bcss_pkg::*; (
	input  logic [9:0] light_sample,
	input  logic [9:0] force_sample,
	input  levels_t    levels,
	input  logic       even_mode,
	input  count_t     count,
	input  levels_t    prev_levels,
	input  logic [3:0] light_threshold,
	output step_t      step
);

	logic [9:0]  light_off;
	logic [13:0] light_num;
	logic [13:0] thresh_num;
	logic        lit;
	logic [23:0] force_prod;
	logic [3:0]  force_scaled;
	levels_t     falls;
	count_t      n_up, n_down, n_next;
	count_t      e_up, e_down, e_tmp;

	// Scaled light >= threshold, compared without dividing
	assign light_off  = light_sample - LIGHT_OFFSET;
	assign light_num  = {1'b0, light_off, 3'b000} + {3'b000, light_off, 1'b0};
	assign thresh_num = LIGHT_DIV * {10'd0, light_threshold};
	assign lit = (light_threshold == 4'd0) ||
		((light_sample >= LIGHT_OFFSET) && (light_num >= thresh_num));

	assign force_prod   = {14'd0, force_sample} * FORCE_RECIP;
	assign force_scaled = force_prod[FORCE_SHIFT +: 4];

	assign falls = prev_levels & ~levels;

	always_comb begin
		// normal mode: saturating steps, show-force last
		n_up   = (falls[BTN_UP] && (count < COUNT_MAX)) ? count + COUNT_ONE : count;
		n_down = (falls[BTN_DOWN] && (n_up > COUNT_ZERO)) ? n_up - COUNT_ONE : n_up;
		n_next = falls[BTN_FORCE] ? COUNT_FORCE : n_down;

		// even mode: land on the next even value up or down
		e_tmp = count + COUNT_TWO;
		e_tmp[0] = 1'b0;
		e_up = (falls[BTN_UP] && (count < COUNT_EVEN_MAX)) ? e_tmp : count;
		e_tmp = e_up - COUNT_ONE;
		e_tmp[0] = 1'b0;
		e_down = (falls[BTN_DOWN] && (e_up > COUNT_ONE)) ? e_tmp : e_up;
	end

	always_comb begin
		step.active = lit;
		if (!lit) begin
			step.count_next = COUNT_ZERO;
			step.prev_next  = prev_levels;
			step.shown      = COUNT_ZERO;
		end else if (even_mode) begin
			step.count_next = e_down;
			step.prev_next  = levels;
			step.shown      = e_down;
		end else begin
			step.count_next = n_next;
			step.prev_next  = levels;
			step.shown      = (n_next < COUNT_ZERO) ? count_t'({4'd0, force_scaled}) : n_next;
		end
	end

endmodule

// File: design/bcss_digits.sv
// Two-digit seven-segment decode of the shown value (-1..99).
// Uses bcss_pkg for the segment map and the divide-by-ten constants.
module bcss_digits import bcss_pkg::*; (
	input  count_t shown,
	input  logic   active,
	output seg_t   tens_segments,
	output seg_t   units_segments
);

	logic [6:0]  mag;
	logic [14:0] tens_prod;
	logic [3:0]  tens;
	logic [6:0]  tens_x10;
	logic [6:0]  units;

	assign mag       = shown[6:0];
	assign tens_prod = {8'd0, mag} * DIV10_RECIP;
	assign tens      = tens_prod[DIV10_SHIFT +: 4];
	assign tens_x10  = {tens[3:0], 3'b000} + {2'b00, tens[3:0], 1'b0};
	assign units     = mag - tens_x10;

	always_comb begin
		if (!active) begin
			tens_segments  = '0;
			units_segments = '0;
		end else if (shown < COUNT_ZERO) begin
			// -1 shown directly: tens reads 0, units blank
			tens_segments  = seg_pattern(4'd0);
			units_segments = '0;
		end else begin
			tens_segments  = seg_pattern(tens);
			units_segments = seg_pattern(units[3:0]);
		end
	end

endmodule
